// ----- src/ckbr_pkg.sv -----
// ckbr_pkg: shared types, constants and helpers for the color-keyed sprite scaler.
// No dependencies; used by every module under src except ckbr_ram.
`timescale 1ns / 1ps

package ckbr_pkg;

    localparam int SCREEN_WIDTH    = 320;
    localparam int SCREEN_HEIGHT   = 240;
    localparam int SPRITE_MAX_SIDE = 128;
    localparam int STORE_DEPTH     = SPRITE_MAX_SIDE * SPRITE_MAX_SIDE;
    localparam int STORE_AW        = $clog2(STORE_DEPTH);
    localparam int QB              = $clog2(SPRITE_MAX_SIDE);   // quotient bits
    localparam int SX_W            = $clog2(SCREEN_WIDTH);
    localparam int SY_W            = $clog2(SCREEN_HEIGHT);
    localparam int PROD_W          = 16;                        // col * side fits here
    localparam int FBA_W           = 17;
    localparam int COLOR_W         = 16;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 16;
    localparam int MQ_DEPTH        = 4;
    localparam int MQ_AW           = $clog2(MQ_DEPTH);
    localparam int OQ_DEPTH        = 16;
    localparam int OQ_AW           = $clog2(OQ_DEPTH);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_DRAW = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPRITE_W  = 3'd0,
        CFG_SPRITE_H  = 3'd1,
        CFG_DEST_W    = 3'd2,
        CFG_DEST_H    = 3'd3,
        CFG_ORIGIN_X  = 3'd4,
        CFG_ORIGIN_Y  = 3'd5,
        CFG_COLOR_KEY = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0]          sprite_width;
        logic [7:0]          sprite_height;
        logic [8:0]          dest_width;
        logic [7:0]          dest_height;
        logic signed [9:0]   dest_origin_x;
        logic signed [8:0]   dest_origin_y;
        logic [COLOR_W-1:0]  key_color;
    } t_cfg;

    // classified word between front and back
    typedef struct packed {
        logic                is_load;
        logic                ok;          // a draw, in box and on screen
        logic [SX_W-1:0]     sx;
        logic [SY_W-1:0]     sy;
        logic [PROD_W-1:0]   px;
        logic [PROD_W-1:0]   py;
        logic [STORE_AW-1:0] ld_addr;
        logic [COLOR_W-1:0]  ld_color;
    } t_item;

    typedef struct packed {
        logic                valid;
        logic                is_load;
        logic                ok;
        logic [FBA_W-1:0]    fb_addr;
        logic [PROD_W-1:0]   remx;
        logic [PROD_W-1:0]   remy;
        logic [QB-1:0]       qx;
        logic [QB-1:0]       qy;
        logic [STORE_AW-1:0] ld_addr;
        logic [COLOR_W-1:0]  ld_color;
    } t_pipe;

    typedef struct packed {
        logic               fb_write;
        logic [FBA_W-1:0]   fb_address;
        logic [COLOR_W-1:0] fb_color;
    } t_res;

    function automatic logic [7:0] clamp_side(input logic [7:0] s);
        return (s > 8'(SPRITE_MAX_SIDE)) ? 8'(SPRITE_MAX_SIDE) : s;
    endfunction

endpackage

// ----- src/color_key_scaled_blit_row_shift_top.sv -----
// Top level of the color-keyed scaled blitter: configuration registers, front
// end and back end. Depends on ckbr_pkg, ckbr_front, ckbr_back.
//
//   channel   handshake                 payload
//   input     i_push / o_full           opcode, load_address, load_color, dest_*, row_shift
//   result    o_empty / i_pop           fb_write, fb_address, fb_color
//   config    i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One word per clock while the result side keeps popping; a word taken by the back end
// passes the issue stage, the 7-stage quotient pipeline and the store read before it
// lands in the result queue.
// Reset is synchronous; the sprite store holds no reset state and needs no sweep.
// A stalled result side fills the 16-entry result queue, then the 4-entry front
// queue, then raises o_full. Config writes are always ready.
`timescale 1ns / 1ps

module color_key_scaled_blit_row_shift_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    output logic                                o_full,
    input  logic                                i_opcode,
    input  logic [13:0]                         i_load_address,
    input  logic [15:0]                         i_load_color,
    input  logic [8:0]                          i_dest_col,
    input  logic [7:0]                          i_dest_row,
    input  logic signed [7:0]                   i_row_shift,
    output logic                                o_empty,
    input  logic                                i_pop,
    output logic                                o_fb_write,
    output logic [16:0]                         o_fb_address,
    output logic [15:0]                         o_fb_color,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ckbr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ckbr_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    ckbr_pkg::t_cfg  r_cfg;
    ckbr_pkg::t_item head;
    ckbr_pkg::t_res  res;
    logic            head_valid;
    logic            take;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sprite_width  <= 8'd128;
            r_cfg.sprite_height <= 8'd128;
            r_cfg.dest_width    <= 9'd160;
            r_cfg.dest_height   <= 8'd160;
            r_cfg.dest_origin_x <= 10'sd80;
            r_cfg.dest_origin_y <= 9'sd60;
            r_cfg.key_color     <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (ckbr_pkg::t_cfg_idx'(i_cfg_index))
                ckbr_pkg::CFG_SPRITE_W:  r_cfg.sprite_width  <= i_cfg_data[7:0];
                ckbr_pkg::CFG_SPRITE_H:  r_cfg.sprite_height <= i_cfg_data[7:0];
                ckbr_pkg::CFG_DEST_W:    r_cfg.dest_width    <= i_cfg_data[8:0];
                ckbr_pkg::CFG_DEST_H:    r_cfg.dest_height   <= i_cfg_data[7:0];
                ckbr_pkg::CFG_ORIGIN_X:  r_cfg.dest_origin_x <= $signed(i_cfg_data[9:0]);
                ckbr_pkg::CFG_ORIGIN_Y:  r_cfg.dest_origin_y <= $signed(i_cfg_data[8:0]);
                ckbr_pkg::CFG_COLOR_KEY: r_cfg.key_color     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ckbr_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_push         (i_push),
        .o_full         (o_full),
        .i_opcode       (i_opcode),
        .i_load_address (i_load_address),
        .i_load_color   (i_load_color),
        .i_dest_col     (i_dest_col),
        .i_dest_row     (i_dest_row),
        .i_row_shift    (i_row_shift),
        .i_take         (take),
        .o_head_valid   (head_valid),
        .o_head         (head)
    );

    ckbr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_take       (take),
        .o_empty      (o_empty),
        .i_pop        (i_pop),
        .o_res        (res)
    );

    assign o_fb_write   = res.fb_write;
    assign o_fb_address = res.fb_address;
    assign o_fb_color   = res.fb_color;

endmodule

// ----- src/ckbr_ram.sv -----
// ckbr_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ckbr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/ckbr_front.sv -----
// ckbr_front: accepts words, clips draw pixels, forms the scale products and
// queues classified words for the back end. Depends on ckbr_pkg.
`timescale 1ns / 1ps

module ckbr_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ckbr_pkg::t_cfg                 i_cfg,
    input  logic                           i_push,
    output logic                           o_full,
    input  logic                           i_opcode,
    input  logic [ckbr_pkg::STORE_AW-1:0]  i_load_address,
    input  logic [ckbr_pkg::COLOR_W-1:0]   i_load_color,
    input  logic [8:0]                     i_dest_col,
    input  logic [7:0]                     i_dest_row,
    input  logic signed [7:0]              i_row_shift,
    input  logic                           i_take,
    output logic                           o_head_valid,
    output ckbr_pkg::t_item                o_head
);

    ckbr_pkg::t_item               r_q [ckbr_pkg::MQ_DEPTH];
    logic [ckbr_pkg::MQ_AW-1:0]    r_wp, r_rp;
    logic [ckbr_pkg::MQ_AW:0]      r_cnt;
    ckbr_pkg::t_item               n_item;
    logic                          push_ok;
    logic                          pop_ok;
    logic [7:0]                    sw, sh;
    logic signed [10:0]            scr_y;
    logic signed [11:0]            scr_x;
    logic                          in_box, on_y, on_x;

    always_comb begin
        sw = ckbr_pkg::clamp_side(i_cfg.sprite_width);
        sh = ckbr_pkg::clamp_side(i_cfg.sprite_height);
        in_box = (i_dest_col < i_cfg.dest_width) && (i_dest_row < i_cfg.dest_height);
        scr_y = 11'(i_cfg.dest_origin_y) + $signed({3'b000, i_dest_row});
        scr_x = 12'(i_cfg.dest_origin_x) + $signed({3'b000, i_dest_col})
              + 12'(i_row_shift);
        on_y = (scr_y >= 11'sd0) && (scr_y < $signed(11'(ckbr_pkg::SCREEN_HEIGHT)));
        on_x = (scr_x >= 12'sd0) && (scr_x < $signed(12'(ckbr_pkg::SCREEN_WIDTH)));

        n_item.is_load  = (i_opcode == ckbr_pkg::OP_LOAD);
        n_item.ok       = (i_opcode == ckbr_pkg::OP_DRAW) && in_box && on_y && on_x;
        n_item.sx       = scr_x[ckbr_pkg::SX_W-1:0];
        n_item.sy       = scr_y[ckbr_pkg::SY_W-1:0];
        n_item.px       = ckbr_pkg::PROD_W'({7'd0, i_dest_col} * {8'd0, sw});
        n_item.py       = ckbr_pkg::PROD_W'({8'd0, i_dest_row} * {8'd0, sh});
        n_item.ld_addr  = i_load_address;
        n_item.ld_color = i_load_color;
    end

    assign o_full       = (r_cnt == (ckbr_pkg::MQ_AW+1)'(ckbr_pkg::MQ_DEPTH));
    assign push_ok      = i_push && !o_full;
    assign o_head_valid = (r_cnt != '0);
    assign pop_ok       = i_take && o_head_valid;
    assign o_head       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop_ok) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (ckbr_pkg::MQ_AW+1)'(push_ok) - (ckbr_pkg::MQ_AW+1)'(pop_ok);
        end
        if (push_ok) begin
            r_q[r_wp] <= n_item;
        end
    end

endmodule

// ----- src/ckbr_back.sv -----
// ckbr_back: pipelined restoring dividers for the source coordinates, sprite
// store access, color key test and the result queue. Depends on ckbr_pkg, ckbr_ram.
`timescale 1ns / 1ps

module ckbr_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ckbr_pkg::t_cfg                i_cfg,
    input  logic                          i_head_valid,
    input  ckbr_pkg::t_item               i_head,
    output logic                          o_take,
    output logic                          o_empty,
    input  logic                          i_pop,
    output ckbr_pkg::t_res                o_res
);

    localparam int NST = ckbr_pkg::QB + 2;

    ckbr_pkg::t_pipe                 r_st [NST];
    ckbr_pkg::t_pipe                 n_st [NST];
    ckbr_pkg::t_res                  r_oq [ckbr_pkg::OQ_DEPTH];
    logic [ckbr_pkg::OQ_AW-1:0]      r_owp, r_orp;
    logic [ckbr_pkg::OQ_AW:0]        r_ocnt;
    logic [ckbr_pkg::OQ_AW:0]        r_cred;     // words in flight plus queued
    logic                            pop_ok;
    logic                            res_push;
    ckbr_pkg::t_res                  n_res;
    logic [ckbr_pkg::COLOR_W-1:0]    rdata;
    logic [ckbr_pkg::STORE_AW-1:0]   raddr;
    logic [7:0]                      sw;
    logic [16:0]                     dx, dy;

    assign sw     = ckbr_pkg::clamp_side(i_cfg.sprite_width);
    assign o_take = i_head_valid && (r_cred < (ckbr_pkg::OQ_AW+1)'(ckbr_pkg::OQ_DEPTH));

    always_comb begin
        n_st[0].valid    = o_take;
        n_st[0].is_load  = i_head.is_load;
        n_st[0].ok       = i_head.ok;
        n_st[0].fb_addr  = ckbr_pkg::FBA_W'({9'd0, i_head.sy}
                                            * ckbr_pkg::FBA_W'(ckbr_pkg::SCREEN_WIDTH))
                         + ckbr_pkg::FBA_W'(i_head.sx);
        n_st[0].remx     = i_head.px;
        n_st[0].remy     = i_head.py;
        n_st[0].qx       = '0;
        n_st[0].qy       = '0;
        n_st[0].ld_addr  = i_head.ld_addr;
        n_st[0].ld_color = i_head.ld_color;
        // one quotient bit per stage, MSB first
        for (int i = 0; i < ckbr_pkg::QB; i++) begin
            n_st[i+1] = r_st[i];
            dx = 17'(i_cfg.dest_width)  << (ckbr_pkg::QB - 1 - i);
            dy = 17'(i_cfg.dest_height) << (ckbr_pkg::QB - 1 - i);
            if ({1'b0, r_st[i].remx} >= dx) begin
                n_st[i+1].remx = r_st[i].remx - ckbr_pkg::PROD_W'(dx);
                n_st[i+1].qx[ckbr_pkg::QB-1-i] = 1'b1;
            end
            if ({1'b0, r_st[i].remy} >= dy) begin
                n_st[i+1].remy = r_st[i].remy - ckbr_pkg::PROD_W'(dy);
                n_st[i+1].qy[ckbr_pkg::QB-1-i] = 1'b1;
            end
        end
        n_st[NST-1] = r_st[NST-2];
        // synchronous reset empties the pipeline
        if (!i_rst_n) begin
            for (int k = 0; k < NST; k++) begin
                n_st[k].valid = 1'b0;
            end
        end
    end

    assign raddr = ckbr_pkg::STORE_AW'({8'd0, r_st[NST-2].qy} * {7'd0, sw})
                 + ckbr_pkg::STORE_AW'(r_st[NST-2].qx);

    ckbr_ram #(
        .WIDTH (ckbr_pkg::COLOR_W),
        .DEPTH (ckbr_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (r_st[NST-2].valid && r_st[NST-2].is_load),
        .i_waddr (r_st[NST-2].ld_addr),
        .i_wdata (r_st[NST-2].ld_color),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        n_res.fb_write   = r_st[NST-1].ok && (rdata != i_cfg.key_color);
        n_res.fb_address = n_res.fb_write ? r_st[NST-1].fb_addr : '0;
        n_res.fb_color   = n_res.fb_write ? rdata : '0;
    end

    assign res_push = r_st[NST-1].valid;
    assign o_empty  = (r_ocnt == '0);
    assign pop_ok   = i_pop && !o_empty;
    assign o_res    = r_oq[r_orp];

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NST; k++) begin
            r_st[k] <= n_st[k];
        end
        if (res_push) begin
            r_oq[r_owp] <= n_res;
        end
        if (!i_rst_n) begin
            r_owp  <= '0;
            r_orp  <= '0;
            r_ocnt <= '0;
            r_cred <= '0;
        end else begin
            if (res_push) begin
                r_owp <= r_owp + 1'b1;
            end
            if (pop_ok) begin
                r_orp <= r_orp + 1'b1;
            end
            r_ocnt <= r_ocnt + (ckbr_pkg::OQ_AW+1)'(res_push)
                    - (ckbr_pkg::OQ_AW+1)'(pop_ok);
            r_cred <= r_cred + (ckbr_pkg::OQ_AW+1)'(o_take)
                    - (ckbr_pkg::OQ_AW+1)'(pop_ok);
        end
    end

endmodule

// ----- tb/ckbr_pixel_checker.sv -----
// ckbr_pixel_checker: watches the input, config and result channels of the sprite scaler,
// predicts each result word and compares it field by field. Depends on ckbr_pkg.
`timescale 1ns / 1ps

module ckbr_pixel_checker
    import ckbr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic                  i_full,
    input  logic                  i_opcode,
    input  logic [13:0]           i_load_address,
    input  logic [15:0]           i_load_color,
    input  logic [8:0]            i_dest_col,
    input  logic [7:0]            i_dest_row,
    input  logic signed [7:0]     i_row_shift,
    input  logic                  i_empty,
    input  logic                  i_pop,
    input  logic                  i_fb_write,
    input  logic [16:0]           i_fb_address,
    input  logic [15:0]           i_fb_color,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam t_cfg CFG_RESET = '{
        sprite_width: 8'd128, sprite_height: 8'd128, dest_width: 9'd160,
        dest_height: 8'd160, dest_origin_x: 10'sd80, dest_origin_y: 9'sd60,
        key_color: 16'h0000
    };

    t_cfg         blit_cfg;
    logic [15:0]  sprite_mem [STORE_DEPTH];
    t_res         expected_pixels [$];

    function automatic int side_of(input logic [7:0] s);
        return (s > SPRITE_MAX_SIDE) ? SPRITE_MAX_SIDE : int'(s);
    endfunction

    // one result word per input word; loads and rejected pixels give all zeros
    function automatic t_res predict_pixel(input logic [8:0] col, input logic [7:0] row,
                                           input logic signed [7:0] shift);
        t_res r;
        int   sx, sy, srcx, srcy, idx, cw, ch;
        logic [15:0] c;
        r = '0;
        if (col >= blit_cfg.dest_width || row >= blit_cfg.dest_height) return r;
        sy = int'($signed(blit_cfg.dest_origin_y)) + int'(row);
        if (sy < 0 || sy >= SCREEN_HEIGHT) return r;
        sx = int'($signed(blit_cfg.dest_origin_x)) + int'(col) + int'(shift);
        if (sx < 0 || sx >= SCREEN_WIDTH) return r;
        cw   = side_of(blit_cfg.sprite_width);
        ch   = side_of(blit_cfg.sprite_height);
        srcy = int'(row) * ch / int'(blit_cfg.dest_height);
        srcx = int'(col) * cw / int'(blit_cfg.dest_width);
        idx  = srcy * cw + srcx;
        if (idx >= STORE_DEPTH) return r;
        c = sprite_mem[idx];
        if (c == blit_cfg.key_color) return r;
        r.fb_write   = 1'b1;
        r.fb_address = FBA_W'(sy * SCREEN_WIDTH + sx);
        r.fb_color   = c;
        return r;
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        blit_cfg     = CFG_RESET;
    end

    always @(posedge i_clk) begin
        t_res exp_w;
        if (!i_rst_n) begin
            blit_cfg = CFG_RESET;
            expected_pixels.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_SPRITE_W:  blit_cfg.sprite_width  = i_cfg_data[7:0];
                    CFG_SPRITE_H:  blit_cfg.sprite_height = i_cfg_data[7:0];
                    CFG_DEST_W:    blit_cfg.dest_width    = i_cfg_data[8:0];
                    CFG_DEST_H:    blit_cfg.dest_height   = i_cfg_data[7:0];
                    CFG_ORIGIN_X:  blit_cfg.dest_origin_x = i_cfg_data[9:0];
                    CFG_ORIGIN_Y:  blit_cfg.dest_origin_y = i_cfg_data[8:0];
                    CFG_COLOR_KEY: blit_cfg.key_color     = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_pop && !i_empty) begin
                if (expected_pixels.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("ERROR: unexpected result word wr=%0d addr=%0d color=%h",
                                 i_fb_write, i_fb_address, i_fb_color);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_w = expected_pixels.pop_front();
                    if (exp_w.fb_write !== i_fb_write || exp_w.fb_address !== i_fb_address ||
                        exp_w.fb_color !== i_fb_color) begin
                        if (o_fail_count < 10)
                            $display("ERROR: expected %0d %0d %h, actual %0d %0d %h",
                                     exp_w.fb_write, exp_w.fb_address, exp_w.fb_color,
                                     i_fb_write, i_fb_address, i_fb_color);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_push && !i_full) begin
                if (i_opcode == OP_LOAD) begin
                    sprite_mem[i_load_address] = i_load_color;
                    expected_pixels.push_back('0);
                end else begin
                    expected_pixels.push_back(predict_pixel(i_dest_col, i_dest_row, i_row_shift));
                end
            end
        end
        o_pending <= expected_pixels.size();
    end

endmodule

// ----- tb/color_key_scaled_blit_row_shift_top_tb.sv -----
// Testbench top for the color-keyed scaled blitter: clock, reset, stimulus and verdict.
// Depends on ckbr_pkg, color_key_scaled_blit_row_shift_top and ckbr_pixel_checker.
`timescale 1ns / 1ps

module color_key_scaled_blit_row_shift_top_tb;
    import ckbr_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int ITEM_GOAL   = 1850;
    localparam int DRAIN_WAIT  = 30;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_push;
    logic                  o_full;
    logic                  i_opcode;
    logic [13:0]           i_load_address;
    logic [15:0]           i_load_color;
    logic [8:0]            i_dest_col;
    logic [7:0]            i_dest_row;
    logic signed [7:0]     i_row_shift;
    logic                  o_empty;
    logic                  i_pop;
    logic                  o_fb_write;
    logic [16:0]           o_fb_address;
    logic [15:0]           o_fb_color;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int fail_count;
    int pending_words;
    int cycle_count;
    int items_sent;
    int pop_burst;
    int pop_level;      // percent chance of pop during the current burst
    bit gapless;
    logic [15:0] palette [4];

    color_key_scaled_blit_row_shift_top u_top (.*);

    ckbr_pixel_checker u_checker (
        .i_clk, .i_rst_n, .i_push, .i_full(o_full), .i_opcode, .i_load_address,
        .i_load_color, .i_dest_col, .i_dest_row, .i_row_shift, .i_empty(o_empty),
        .i_pop, .i_fb_write(o_fb_write), .i_fb_address(o_fb_address),
        .i_fb_color(o_fb_color), .i_cfg_valid, .i_cfg_ready(o_cfg_ready),
        .i_cfg_index, .i_cfg_data, .o_fail_count(fail_count), .o_pending(pending_words)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("color_key_scaled_blit_row_shift_top test failed");
            $finish;
        end
    end

    // result side: bursts of full rate, random pops and long stalls
    always @(posedge i_clk) begin
        int r;
        if (pop_burst == 0) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                pop_burst <= $urandom_range(1, 8);
                pop_level <= $urandom_range(30, 90);
            end else if (r < 90) begin
                pop_burst <= $urandom_range(10, 60);
                pop_level <= 100;
            end else begin
                pop_burst <= $urandom_range(30, 200);
                pop_level <= 0;
            end
            i_pop <= 1'b0;
        end else begin
            pop_burst <= pop_burst - 1;
            i_pop <= ($urandom_range(1, 100) <= pop_level);
        end
    end

    function automatic int pick_gap();
        int r;
        if (gapless) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 80);
    endfunction

    task automatic send_word(input logic op, input logic [13:0] addr, input logic [15:0] color,
                             input logic [8:0] col, input logic [7:0] row,
                             input logic [7:0] shift);
        int gap;
        i_push         <= 1'b1;
        i_opcode       <= op;
        i_load_address <= addr;
        i_load_color   <= color;
        i_dest_col     <= col;
        i_dest_row     <= row;
        i_row_shift    <= shift;
        do @(posedge i_clk); while (o_full);
        items_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            i_push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic load_word(input logic [13:0] addr, input logic [15:0] color);
        send_word(OP_LOAD, addr, color, 9'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic draw_word(input logic [8:0] col, input logic [7:0] row,
                             input logic [7:0] shift);
        send_word(OP_DRAW, 14'($urandom), 16'($urandom), col, row, shift);
    endtask

    // push drops before the next edge so the last word is not taken twice
    task automatic drain();
        i_push <= 1'b0;
        @(posedge i_clk);
        while (pending_words != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // drain, program all registers, then fill the part of the store the sprite can reach
    task automatic setup_phase(input int sw, input int sh, input int dw, input int dh,
                               input int ox, input int oy, input bit use_palette,
                               input bit key_hit);
        int cw, ch, words;
        logic [15:0] key;
        drain();
        foreach (palette[k]) palette[k] = 16'($urandom);
        key = key_hit ? palette[0] : 16'($urandom);
        write_reg(CFG_SPRITE_W, 16'(sw));
        write_reg(CFG_SPRITE_H, 16'(sh));
        write_reg(CFG_DEST_W, 16'(dw));
        write_reg(CFG_DEST_H, 16'(dh));
        write_reg(CFG_ORIGIN_X, 16'(ox));
        write_reg(CFG_ORIGIN_Y, 16'(oy));
        write_reg(CFG_COLOR_KEY, key);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        cw = (sw > SPRITE_MAX_SIDE) ? SPRITE_MAX_SIDE : sw;
        ch = (sh > SPRITE_MAX_SIDE) ? SPRITE_MAX_SIDE : sh;
        words = (cw * ch < 1) ? 1 : cw * ch;
        for (int a = 0; a < words; a++)
            load_word(14'(a), use_palette ? palette[$urandom_range(0, 3)] : 16'($urandom));
    endtask

    task automatic random_phase();
        int sw, sh, dw, dh, ox, oy, n, r;
        r  = $urandom_range(0, 9);
        sw = $urandom_range(1, 16);
        sh = $urandom_range(1, 16);
        if (r == 0) begin
            sw = $urandom_range(128, 255);
            sh = $urandom_range(0, 2);
        end else if (r == 1) begin
            sh = $urandom_range(128, 255);
            sw = $urandom_range(0, 2);
        end
        dw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 320);
        dh = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 240);
        ox = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023) - 512
                                         : $urandom_range(0, 360) - 40;
        oy = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 511) - 256
                                         : $urandom_range(0, 260) - 20;
        gapless = ($urandom_range(0, 3) == 0);
        setup_phase(sw, sh, dw, dh, ox, oy, $urandom_range(0, 1), $urandom_range(0, 1));
        n = $urandom_range(60, 200);
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                load_word(14'($urandom), 16'($urandom));   // noise load anywhere
            end else if (r < 14 || dw == 0 || dh == 0) begin
                draw_word(9'($urandom), 8'($urandom), 8'($urandom));
            end else begin
                draw_word(9'($urandom_range(0, dw - 1)), 8'($urandom_range(0, dh - 1)),
                          (r < 20) ? 8'($urandom) : 8'($urandom_range(0, 128) - 64));
            end
            if (items_sent >= ITEM_GOAL) break;
            if (i == n / 2 && $urandom_range(0, 7) == 0) drain();
        end
    endtask

    initial begin
        cycle_count    = 0;
        items_sent     = 0;
        pop_burst      = 0;
        pop_level      = 0;
        gapless        = 1'b0;
        i_rst_n        = 1'b0;
        i_push         = 1'b0;
        i_pop          = 1'b0;
        i_opcode       = OP_LOAD;
        i_load_address = '0;
        i_load_color   = '0;
        i_dest_col     = '0;
        i_dest_row     = '0;
        i_row_shift    = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = CFG_SPRITE_W;
        i_cfg_data     = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: box corners, shift extremes, outside-box and off-screen pixels
        setup_phase(4, 4, 16, 8, 0, 0, 1, 1);
        draw_word(9'd0, 8'd0, 8'sd0);
        draw_word(9'd15, 8'd7, 8'sd0);
        draw_word(9'd0, 8'd0, -8'sd64);
        draw_word(9'd15, 8'd7, 8'sd64);
        draw_word(9'd3, 8'd2, -8'sd128);
        draw_word(9'd3, 8'd2, 8'sd127);
        draw_word(9'd16, 8'd0, 8'sd0);
        draw_word(9'd511, 8'd255, 8'sd0);
        draw_word(9'd0, 8'd8, 8'sd0);
        load_word(14'h3FFF, 16'hFFFF);
        load_word(14'd0, palette[0]);
        draw_word(9'd0, 8'd0, 8'sd0);
        // full-size box at the far corner, clipped both ways
        setup_phase(4, 4, 320, 240, -320, -240, 0, 0);
        draw_word(9'd319, 8'd239, 8'sd64);
        draw_word(9'd319, 8'd239, 8'sd1);
        draw_word(9'd0, 8'd239, 8'sd0);
        setup_phase(2, 2, 511, 255, 511, 255, 0, 0);
        draw_word(9'd0, 8'd0, -8'sd128);
        // saturated and zero sprite sizes, zero destination size
        setup_phase(255, 1, 40, 10, 10, 10, 0, 0);
        draw_word(9'd39, 8'd9, 8'sd0);
        setup_phase(0, 0, 8, 8, 319, 239, 0, 0);
        draw_word(9'd0, 8'd0, 8'sd0);
        draw_word(9'd7, 8'd7, -8'sd7);
        setup_phase(3, 3, 0, 0, 0, 0, 0, 0);
        draw_word(9'd0, 8'd0, 8'sd0);
        setup_phase(1, 255, 12, 200, -12, 20, 1, 1);
        draw_word(9'd11, 8'd199, 8'sd5);

        while (items_sent < ITEM_GOAL) random_phase();

        drain();
        if (fail_count == 0) begin
            $display("color_key_scaled_blit_row_shift_top test passed");
        end else begin
            $display("color_key_scaled_blit_row_shift_top test failed");
        end
        $finish;
    end

endmodule

// ----- color_key_scaled_blit_row_shift_top.f -----
src/ckbr_pkg.sv
src/ckbr_ram.sv
src/ckbr_front.sv
src/ckbr_back.sv
src/color_key_scaled_blit_row_shift_top.sv
tb/ckbr_pixel_checker.sv
tb/color_key_scaled_blit_row_shift_top_tb.sv
